// ===== hdl/tile_frustum_planes_unit_assert.svh =====
// Assertion helpers shared by the tile frustum plane RTL.
// Each check is clocked on clk and held off while rst is high.
`ifndef TILE_FRUSTUM_PLANES_UNIT_ASSERT_SVH
`define TILE_FRUSTUM_PLANES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfp: implication check failed");
`define TFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfp: next-cycle check failed");
`else
`define TFP_ASSERT_IMP(lbl, ante, cons)
`define TFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/tfp_pkg.sv =====
`default_nettype none
package tfp_pkg;

  // Tile geometry and coefficient format
  localparam int TILE_SIZE  = 16;
  localparam int COEF_WIDTH = 16;

  // Corner pixel coordinate width (up to 256 tiles per axis)
  localparam int PX_W   = $clog2(256 * TILE_SIZE + 1);
  // NDC in Q.14, signed
  localparam int NDC_W  = PX_W + 16;
  // Clip components: two coefficient products plus the constant lanes
  localparam int CLIP_W = COEF_WIDTH + NDC_W + 2;
  // Vector fed to normalization, one bit of headroom for negation
  localparam int VEC_W  = CLIP_W + 1;
  // Magnitude bound after prescaling
  localparam int MAG_W  = 30;
  // Shared multiplier
  localparam int MUL_W  = 31;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 64;
  // Square root and divider sizes
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;
  localparam int DVD_W  = MAG_W + 14;
  localparam int DVS_W  = 31;
  localparam int QV_W   = 15;

  localparam int Q14_ONE = 16384;

  // Request queue depth (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PROJ_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PROJ_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PROJ_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PROJ_W = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCR_W  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCR_H  = 3'd5;

  localparam logic [12:0] SCR_W_RESET = 13'd1920;
  localparam logic [12:0] SCR_H_RESET = 13'd1080;

  // One tile request after corner pixel expansion
  typedef struct packed {
    logic [PX_W-1:0] x0;
    logic [PX_W-1:0] x1;
    logic [PX_W-1:0] y0;
    logic [PX_W-1:0] y1;
    logic [23:0]     depth_near;
    logic [23:0]     depth_far;
  } item_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [3:0][63:0] proj_row;
    logic [12:0]      screen_width;
    logic [12:0]      screen_height;
  } cfg_t;

  // Signed coefficient from lane k of a projection row
  function automatic logic signed [COEF_WIDTH-1:0] coef_lane(logic [63:0] row,
                                                             logic [1:0] k);
    return $signed(row[{k, 4'b0000} +: COEF_WIDTH]);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tile_frustum_planes_unit.sv =====
`default_nettype none
// Tile frustum side planes. Pulse start with a tile index and depth range
// while busy is low; the request is queued (two deep) and later yields four
// results in the order top, right, bottom, left, each shown for one cycle
// with strobe high and last_plane marking the left plane. Results cannot be
// held off, so the receiver must take every strobe. Each tile runs four NDC
// divisions and up to 24 normalization divisions on a shared
// one-bit-per-cycle divider, and each of the eight normalizations also runs
// a square root after prescaling its magnitudes. The user must write projection
// rows and screen size through wr_en/wr_index/wr_data only while no tile is
// pending; the block itself does not enforce this.
module tile_frustum_planes_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [7:0]                    tile_x,
  input  wire logic [7:0]                    tile_y,
  input  wire logic [23:0]                   depth_near_in,
  input  wire logic [23:0]                   depth_far_in,
  input  wire logic                          wr_en,
  input  wire logic [tfp_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [63:0]                   wr_data,
  output logic                               strobe,
  output logic [1:0]                         plane_index,
  output logic signed [15:0]                 normal_x,
  output logic signed [15:0]                 normal_y,
  output logic signed [15:0]                 normal_z,
  output logic [23:0]                        depth_near_out,
  output logic [23:0]                        depth_far_out,
  output logic                               last_plane
);
  tfp_pkg::cfg_t  cfg;
  tfp_pkg::head_t head;
  logic           pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.proj_row      <= '0;
      cfg.screen_width  <= tfp_pkg::SCR_W_RESET;
      cfg.screen_height <= tfp_pkg::SCR_H_RESET;
    end else if (wr_en) begin
      case (wr_index)
        tfp_pkg::REG_PROJ_X: cfg.proj_row[0]      <= wr_data;
        tfp_pkg::REG_PROJ_Y: cfg.proj_row[1]      <= wr_data;
        tfp_pkg::REG_PROJ_Z: cfg.proj_row[2]      <= wr_data;
        tfp_pkg::REG_PROJ_W: cfg.proj_row[3]      <= wr_data;
        tfp_pkg::REG_SCR_W:  cfg.screen_width     <= wr_data[12:0];
        tfp_pkg::REG_SCR_H:  cfg.screen_height    <= wr_data[12:0];
        default: ;
      endcase
    end
  end

  tfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .tile_x        (tile_x),
    .tile_y        (tile_y),
    .depth_near_in (depth_near_in),
    .depth_far_in  (depth_far_in),
    .pop           (pop),
    .head          (head)
  );

  tfp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .cfg            (cfg),
    .strobe         (strobe),
    .plane_index    (plane_index),
    .normal_x       (normal_x),
    .normal_y       (normal_y),
    .normal_z       (normal_z),
    .depth_near_out (depth_near_out),
    .depth_far_out  (depth_far_out),
    .last_plane     (last_plane)
  );
endmodule
`default_nettype wire

// ===== hdl/tfp_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle
module tfp_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [tfp_pkg::DVD_W-1:0]  dividend,
  input  wire logic [tfp_pkg::DVS_W-1:0]  divisor,
  output logic                            done,
  output logic [tfp_pkg::DVD_W-1:0]       quotient
);
  localparam int CNT_W = $clog2(tfp_pkg::DVD_W + 1);

  logic [tfp_pkg::DVS_W:0]   rem;
  logic [tfp_pkg::DVS_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic [tfp_pkg::DVS_W:0]   shifted;
  logic                      fits;

  // Trial subtract of the next partial remainder
  always_comb begin
    shifted = {rem[tfp_pkg::DVS_W-1:0], quotient[tfp_pkg::DVD_W-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
        cnt      <= CNT_W'(tfp_pkg::DVD_W);
      end else if (busy) begin
        rem      <= fits ? shifted - {1'b0, dvs} : shifted;
        quotient <= {quotient[tfp_pkg::DVD_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tfp_isqrt.sv =====
`default_nettype none
// Integer square root, one result bit per cycle
module tfp_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tfp_pkg::SQ_W-1:0]  radicand,
  output logic                           done,
  output logic [tfp_pkg::ROOT_W-1:0]     root
);
  logic [tfp_pkg::SQ_W-1:0] x;
  logic [tfp_pkg::SQ_W-1:0] r;
  logic [tfp_pkg::SQ_W-1:0] b;
  logic                     busy;
  logic [tfp_pkg::SQ_W-1:0] trial;

  assign trial = r + b;
  assign root  = r[tfp_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x    <= radicand;
        r    <= '0;
        b    <= tfp_pkg::SQ_W'(1) << (tfp_pkg::SQ_W - 2);
      end else if (busy) begin
        // Take one bit pair per cycle
        if (x >= trial) begin
          x <= x - trial;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b <= b >> 2;
        if (b[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tfp_front.sv =====
`default_nettype none
`include "tile_frustum_planes_unit_assert.svh"
// Request intake: expand tile to corner pixels and queue it
module tfp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [7:0]          tile_x,
  input  wire logic [7:0]          tile_y,
  input  wire logic [23:0]         depth_near_in,
  input  wire logic [23:0]         depth_far_in,
  input  wire logic                pop,
  output tfp_pkg::head_t           head
);
  tfp_pkg::item_t                 q [tfp_pkg::QDEPTH];
  logic [tfp_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tfp_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tfp_pkg::QCNT_W-1:0]     count;
  logic                           push;
  tfp_pkg::item_t                 incoming;

  assign busy = count == tfp_pkg::QCNT_W'(tfp_pkg::QDEPTH);
  assign push = start && !busy;

  // Corner pixel coordinates of the tile
  always_comb begin
    incoming.x0 = tfp_pkg::PX_W'(tile_x) * tfp_pkg::PX_W'(tfp_pkg::TILE_SIZE);
    incoming.x1 = tfp_pkg::PX_W'({1'b0, tile_x} + 9'd1) *
                  tfp_pkg::PX_W'(tfp_pkg::TILE_SIZE);
    incoming.y0 = tfp_pkg::PX_W'(tile_y) * tfp_pkg::PX_W'(tfp_pkg::TILE_SIZE);
    incoming.y1 = tfp_pkg::PX_W'({1'b0, tile_y} + 9'd1) *
                  tfp_pkg::PX_W'(tfp_pkg::TILE_SIZE);
    incoming.depth_near = depth_near_in;
    incoming.depth_far  = depth_far_in;
  end

  assign head.valid = count != '0;
  assign head.item  = q[rd_ptr];

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TFP_ASSERT_IMP(a_pop_nonempty, pop, count != '0)
  `TFP_ASSERT_NXT(a_push_grows, push && !pop, count == $past(count) + 1'b1)
  `TFP_ASSERT_IMP(a_count_bound, 1'b1, count <= tfp_pkg::QCNT_W'(tfp_pkg::QDEPTH))
endmodule
`default_nettype wire

// ===== hdl/tfp_back.sv =====
`default_nettype none
`include "tile_frustum_planes_unit_assert.svh"
// Plane sequencer: NDC, corner rays, cross products, normalization
module tfp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tfp_pkg::head_t     head,
  output logic                    pop,
  input  wire tfp_pkg::cfg_t      cfg,
  output logic                    strobe,
  output logic [1:0]              plane_index,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic [23:0]             depth_near_out,
  output logic [23:0]             depth_far_out,
  output logic                    last_plane
);
  localparam int NDC_W  = tfp_pkg::NDC_W;
  localparam int CLIP_W = tfp_pkg::CLIP_W;
  localparam int VEC_W  = tfp_pkg::VEC_W;
  localparam int MAG_W  = tfp_pkg::MAG_W;
  localparam int MUL_W  = tfp_pkg::MUL_W;
  localparam int PROD_W = tfp_pkg::PROD_W;
  localparam int ACC_W  = tfp_pkg::ACC_W;
  localparam int DVD_W  = tfp_pkg::DVD_W;
  localparam int DVS_W  = tfp_pkg::DVS_W;
  localparam int QV_W   = tfp_pkg::QV_W;
  localparam int CW     = tfp_pkg::COEF_WIDTH;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DIV   = 14'b00000000000010,
    S_CMUL  = 14'b00000000000100,
    S_CACC  = 14'b00000000001000,
    S_RAY   = 14'b00000000010000,
    S_UABS  = 14'b00000000100000,
    S_USHF  = 14'b00000001000000,
    S_USQM  = 14'b00000010000000,
    S_USQA  = 14'b00000100000000,
    S_USQRT = 14'b00001000000000,
    S_UDIV  = 14'b00010000000000,
    S_UDONE = 14'b00100000000000,
    S_XMUL  = 14'b01000000000000,
    S_XACC  = 14'b10000000000000
  } state_t;

  state_t                     state;
  tfp_pkg::item_t             cur;
  logic signed [NDC_W-1:0]    ndc [4];
  logic signed [CLIP_W-1:0]   clip [4];
  logic signed [15:0]         rays [4][3];
  logic signed [VEC_W-1:0]    vec [3];
  logic [VEC_W-1:0]           mag [3];
  logic                       neg [3];
  logic [QV_W-1:0]            qv [3];
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic [1:0]                 idx;
  logic                       term;
  logic [2:0]                 xstep;
  logic [1:0]                 corner;
  logic [1:0]                 plane;
  logic                       norm_phase;

  // Shared unit handshakes
  logic                       div_start;
  logic [DVD_W-1:0]           dvd;
  logic [DVS_W-1:0]           dvs;
  logic                       div_done;
  logic [DVD_W-1:0]           div_quo;
  logic                       sq_start;
  logic                       sq_done;
  logic [tfp_pkg::ROOT_W-1:0] root;

  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic                       cx;
  logic                       cy;
  logic signed [CW-1:0]       coef_t;
  logic signed [CW-1:0]       coef_z;
  logic signed [CW-1:0]       coef_w;
  logic signed [CW:0]         coef_zw;
  logic signed [ACC_W-1:0]    acc_base;
  logic [1:0]                 ia;
  logic [1:0]                 ib;
  logic signed [15:0]         res [3];
  logic [DVS_W-1:0]           sw_eff;
  logic [DVS_W-1:0]           sh_eff;
  logic                       mag_big;
  logic [1:0]                 idx_inc;

  tfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  tfp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc[tfp_pkg::SQ_W-1:0]),
    .done     (sq_done),
    .root     (root)
  );

  // Pixel coordinate for an NDC slot: x0, x1, y0, y1
  function automatic logic [DVD_W-1:0] px_dividend(tfp_pkg::item_t it, logic [1:0] k);
    logic [tfp_pkg::PX_W-1:0] p;
    case (k)
      2'd0:    p = it.x0;
      2'd1:    p = it.x1;
      2'd2:    p = it.y0;
      default: p = it.y1;
    endcase
    return DVD_W'(p) << 15;
  endfunction

  assign pop     = (state == S_IDLE) && head.valid;
  assign idx_inc = idx + 2'd1;
  assign sw_eff  = (cfg.screen_width  == '0) ? DVS_W'(1) : DVS_W'(cfg.screen_width);
  assign sh_eff  = (cfg.screen_height == '0) ? DVS_W'(1) : DVS_W'(cfg.screen_height);

  // Operand selection for the shared multiplier
  always_comb begin
    cx       = (corner == 2'd1) || (corner == 2'd2);
    cy       = corner[1];
    coef_t   = tfp_pkg::coef_lane(cfg.proj_row[idx], {1'b0, term});
    coef_z   = tfp_pkg::coef_lane(cfg.proj_row[idx], 2'd2);
    coef_w   = tfp_pkg::coef_lane(cfg.proj_row[idx], 2'd3);
    coef_zw  = (CW + 1)'(coef_z) + (CW + 1)'(coef_w);
    acc_base = ACC_W'(coef_zw) <<< 14;
    case (xstep)
      3'd0:    begin ia = 2'd1; ib = 2'd2; end
      3'd1:    begin ia = 2'd2; ib = 2'd1; end
      3'd2:    begin ia = 2'd2; ib = 2'd0; end
      3'd3:    begin ia = 2'd0; ib = 2'd2; end
      3'd4:    begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd0; end
    endcase
    case (state)
      S_CMUL: begin
        mul_a = MUL_W'(coef_t);
        mul_b = term ? MUL_W'(ndc[{1'b1, cy}]) : MUL_W'(ndc[{1'b0, cx}]);
      end
      S_USQM: begin
        mul_a = $signed(MUL_W'(mag[idx][MAG_W-1:0]));
        mul_b = $signed(MUL_W'(mag[idx][MAG_W-1:0]));
      end
      S_XMUL: begin
        mul_a = MUL_W'(rays[plane][ia]);
        mul_b = MUL_W'(rays[plane + 2'd1][ib]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mag_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_big = mag_big | (|mag[i][VEC_W-1:MAG_W]);
      res[i]  = neg[i] ? -$signed({1'b0, qv[i]}) : $signed({1'b0, qv[i]});
    end
  end

  // Registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      case (state)
        S_IDLE: begin
          // Take the next tile and launch the first NDC division
          if (head.valid) begin
            cur       <= head.item;
            idx       <= 2'd0;
            dvd       <= px_dividend(head.item, 2'd0);
            dvs       <= sw_eff;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ndc[idx] <= $signed({1'b0, div_quo[NDC_W-2:0]}) - NDC_W'(tfp_pkg::Q14_ONE);
            if (idx == 2'd3) begin
              corner     <= 2'd0;
              idx        <= 2'd0;
              term       <= 1'b0;
              norm_phase <= 1'b0;
              state      <= S_CMUL;
            end else begin
              idx       <= idx_inc;
              dvd       <= px_dividend(cur, idx_inc);
              dvs       <= idx_inc[1] ? sh_eff : sw_eff;
              div_start <= 1'b1;
            end
          end
        end
        S_CMUL: begin
          state <= S_CACC;
        end
        S_CACC: begin
          // Accumulate one clip row
          if (!term) begin
            acc   <= acc_base + ACC_W'(prod);
            term  <= 1'b1;
            state <= S_CMUL;
          end else begin
            clip[idx] <= CLIP_W'(acc + ACC_W'(prod));
            term      <= 1'b0;
            if (idx == 2'd3) begin
              state <= S_RAY;
            end else begin
              idx   <= idx_inc;
              state <= S_CMUL;
            end
          end
        end
        S_RAY: begin
          // Zero w gives a zero ray; negative w flips xyz
          if (clip[3] == '0) begin
            for (int i = 0; i < 3; i++) begin
              rays[corner][i] <= '0;
            end
            if (corner == 2'd3) begin
              norm_phase <= 1'b1;
              plane      <= 2'd0;
              xstep      <= 3'd0;
              state      <= S_XMUL;
            end else begin
              corner <= corner + 2'd1;
              idx    <= 2'd0;
              state  <= S_CMUL;
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              vec[i] <= clip[3][CLIP_W-1] ? -VEC_W'(clip[i]) : VEC_W'(clip[i]);
            end
            state <= S_UABS;
          end
        end
        S_UABS: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i][VEC_W-1];
            mag[i] <= vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
          end
          state <= S_USHF;
        end
        S_USHF: begin
          // Prescale until every magnitude is below the square limit
          if (mag_big) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            idx   <= 2'd0;
            acc   <= '0;
            state <= S_USQM;
          end
        end
        S_USQM: begin
          state <= S_USQA;
        end
        S_USQA: begin
          acc <= acc + ACC_W'(prod);
          if (idx == 2'd2) begin
            sq_start <= 1'b1;
            state    <= S_USQRT;
          end else begin
            idx   <= idx_inc;
            state <= S_USQM;
          end
        end
        S_USQRT: begin
          if (sq_done) begin
            if (root == '0) begin
              for (int i = 0; i < 3; i++) begin
                qv[i] <= '0;
              end
              state <= S_UDONE;
            end else begin
              idx       <= 2'd0;
              dvd       <= DVD_W'(mag[0][MAG_W-1:0]) << 14;
              dvs       <= DVS_W'(root);
              div_start <= 1'b1;
              state     <= S_UDIV;
            end
          end
        end
        S_UDIV: begin
          if (div_done) begin
            qv[idx] <= div_quo[QV_W-1:0];
            if (idx == 2'd2) begin
              state <= S_UDONE;
            end else begin
              idx       <= idx_inc;
              dvd       <= DVD_W'(mag[idx_inc][MAG_W-1:0]) << 14;
              div_start <= 1'b1;
            end
          end
        end
        S_UDONE: begin
          if (!norm_phase) begin
            // Store the corner ray and move to the next corner
            for (int i = 0; i < 3; i++) begin
              rays[corner][i] <= res[i];
            end
            if (corner == 2'd3) begin
              norm_phase <= 1'b1;
              plane      <= 2'd0;
              xstep      <= 3'd0;
              state      <= S_XMUL;
            end else begin
              corner <= corner + 2'd1;
              idx    <= 2'd0;
              state  <= S_CMUL;
            end
          end else begin
            // Emit one plane
            strobe         <= 1'b1;
            plane_index    <= plane;
            normal_x       <= res[0];
            normal_y       <= res[1];
            normal_z       <= res[2];
            depth_near_out <= cur.depth_near;
            depth_far_out  <= cur.depth_far;
            last_plane     <= plane == 2'd3;
            if (plane == 2'd3) begin
              state <= S_IDLE;
            end else begin
              plane <= plane + 2'd1;
              xstep <= 3'd0;
              state <= S_XMUL;
            end
          end
        end
        S_XMUL: begin
          state <= S_XACC;
        end
        S_XACC: begin
          // Cross product of adjacent rays, one product per step
          if (!xstep[0]) begin
            acc <= ACC_W'(prod);
          end else begin
            vec[xstep[2:1]] <= VEC_W'(acc - ACC_W'(prod));
          end
          if (xstep == 3'd5) begin
            state <= S_UABS;
          end else begin
            xstep <= xstep + 3'd1;
            state <= S_XMUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TFP_ASSERT_IMP(a_strobe_src, strobe, $past(state == S_UDONE))
  `TFP_ASSERT_IMP(a_last_plane, strobe && last_plane, plane_index == 2'd3)
  `TFP_ASSERT_IMP(a_div_wait, div_start, state == S_DIV || state == S_UDIV)
endmodule
`default_nettype wire
